[rtl/core/assert_macros.svh]
// Assertion macros used by the top level for its concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and held off while rst_n is low.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and held off while rst_n is low.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/itoa_pkg.sv]
// Package with the transaction types, widths and character constants of the converter.
package itoa_pkg;

  // Width of the value field and derived counter widths.
  localparam int VALUE_BITS = 32;
  localparam int RADIX_BITS = 6;
  localparam int DIGIT_BITS = 6;
  localparam int CNT_W      = $clog2(VALUE_BITS);
  localparam int ND_W       = $clog2(VALUE_BITS + 1);

  // Radix limits and the radixes that get special treatment.
  localparam logic [RADIX_BITS-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_BITS-1:0] RADIX_MAX = 6'd36;
  localparam logic [RADIX_BITS-1:0] RADIX_BIN = 6'd2;
  localparam logic [RADIX_BITS-1:0] RADIX_OCT = 6'd8;
  localparam logic [RADIX_BITS-1:0] RADIX_DEC = 6'd10;
  localparam logic [RADIX_BITS-1:0] RADIX_HEX = 6'd16;

  // ASCII codes used in the text.
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_LOWA  = 8'h61;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_X     = 8'h78;
  localparam logic [7:0] CHAR_B     = 8'h62;

  // Input transaction.
  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic [RADIX_BITS-1:0]        radix;
  } itoa_in_t;

  // Output transaction: one character of the text.
  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } itoa_out_t;

  // Status returned by the shared divider.
  typedef struct packed {
    logic busy;
    logic done;
  } itoa_div_stat_t;

  // Maps a digit value to its ASCII code, lower-case letters above nine.
  function automatic logic [7:0] digit_char(input logic [DIGIT_BITS-1:0] d);
    logic [7:0] d8;
    d8 = {2'b00, d};
    if (d < 6'd10) begin
      return CHAR_ZERO + d8;
    end
    return CHAR_LOWA + d8 - 8'd10;
  endfunction

endpackage

[rtl/core/itoa_divider.sv]
// Bit-serial restoring divider: one quotient bit per cycle by a small radix.
module itoa_divider (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic [itoa_pkg::VALUE_BITS-1:0]        dividend,
  input  logic [itoa_pkg::RADIX_BITS-1:0]        divisor,
  output logic [itoa_pkg::VALUE_BITS-1:0]        quotient,
  output logic [itoa_pkg::DIGIT_BITS-1:0]        remainder,
  output itoa_pkg::itoa_div_stat_t               stat
);

  logic [itoa_pkg::VALUE_BITS-1:0] quo_r, quo_nxt;
  logic [itoa_pkg::DIGIT_BITS-1:0] rem_r, rem_nxt;
  logic [itoa_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                            busy_r, busy_nxt;
  logic                            done_r, done_nxt;
  logic [itoa_pkg::DIGIT_BITS:0]   rem_sh;
  logic [itoa_pkg::DIGIT_BITS:0]   rem_sub;
  logic                            fits;

  // One restoring step: shift in the next dividend bit and try the subtraction.
  always_comb begin
    rem_sh  = {rem_r, quo_r[itoa_pkg::VALUE_BITS-1]};
    rem_sub = rem_sh - {1'b0, divisor};
    fits    = (rem_sh >= {1'b0, divisor});
  end

  // Step sequencing: load on start, then one bit per cycle until the count runs out.
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = itoa_pkg::CNT_W'(itoa_pkg::VALUE_BITS - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[itoa_pkg::VALUE_BITS-2:0], fits};
      rem_nxt = fits ? rem_sub[itoa_pkg::DIGIT_BITS-1:0] : rem_sh[itoa_pkg::DIGIT_BITS-1:0];
      cnt_nxt = cnt_r - itoa_pkg::CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

[rtl/core/integer_to_ascii_radix_top.sv]
// Top level of the integer to ASCII text converter with sequencer and output register.
// Converts one signed value at a time into ASCII text in a radix from 2 to 36, most
// significant character first, with last set on the final character. Radix 10 prints
// negative values with a leading minus sign; other radixes read the value as unsigned and
// prefix "0x", "0" or "0b" for 16, 8 and 2. Zero prints as "0". A radix below 2 acts as 2,
// one above 36 as 36. Digits come from one shared bit-serial divider, one run per digit,
// and the characters then leave at one per cycle while out_stall is low. in_stall stays
// high from acceptance until the last character has been loaded into the output register.
`include "assert_macros.svh"

module integer_to_ascii_radix_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  itoa_pkg::itoa_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output itoa_pkg::itoa_out_t out_data
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_START = 4'b0010,
    S_WAIT  = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t                            state_r, state_nxt;
  logic [itoa_pkg::VALUE_BITS-1:0]   mag_r, mag_nxt;
  logic [itoa_pkg::RADIX_BITS-1:0]   rad_r, rad_nxt;
  logic                              neg_r, neg_nxt;
  logic                              p0_r, p0_nxt;
  logic                              p1_r, p1_nxt;
  logic [itoa_pkg::ND_W-1:0]         nd_r, nd_nxt;
  logic [itoa_pkg::DIGIT_BITS-1:0]   stack_r [itoa_pkg::VALUE_BITS];
  logic                              out_valid_r, out_valid_nxt;
  itoa_pkg::itoa_out_t               out_data_r, out_data_nxt;

  logic                              in_acc;
  logic                              load_ok;
  logic                              push;
  logic                              pop;
  logic [itoa_pkg::RADIX_BITS-1:0]   rad_sat;
  logic [itoa_pkg::VALUE_BITS-1:0]   val_u;
  logic                              in_neg;
  logic                              in_zero;
  logic                              div_start;
  logic [itoa_pkg::VALUE_BITS-1:0]   div_quo;
  logic [itoa_pkg::DIGIT_BITS-1:0]   div_rem;
  itoa_pkg::itoa_div_stat_t          div_stat;

  // Shared divider producing one digit per run, least significant first.
  itoa_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (mag_r),
    .divisor   (rad_r),
    .quotient  (div_quo),
    .remainder (div_rem),
    .stat      (div_stat)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign load_ok   = !out_valid_r || !out_stall;
  assign div_start = (state_r == S_START);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Input decode: clamp the radix and work out sign and magnitude.
  always_comb begin
    val_u = in_data.value;
    priority if (in_data.radix < itoa_pkg::RADIX_MIN) begin
      rad_sat = itoa_pkg::RADIX_MIN;
    end else if (in_data.radix > itoa_pkg::RADIX_MAX) begin
      rad_sat = itoa_pkg::RADIX_MAX;
    end else begin
      rad_sat = in_data.radix;
    end
    in_zero = (val_u == '0);
    in_neg  = (rad_sat == itoa_pkg::RADIX_DEC) && val_u[itoa_pkg::VALUE_BITS-1];
  end

  // Sequencer: divide until the quotient reaches zero, then send the text.
  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    rad_nxt       = rad_r;
    neg_nxt       = neg_r;
    p0_nxt        = p0_r;
    p1_nxt        = p1_r;
    nd_nxt        = nd_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    push          = 1'b0;
    pop           = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          rad_nxt   = rad_sat;
          neg_nxt   = in_neg;
          mag_nxt   = in_neg ? ('0 - val_u) : val_u;
          p0_nxt    = !in_zero && ((rad_sat == itoa_pkg::RADIX_HEX) ||
                                   (rad_sat == itoa_pkg::RADIX_OCT) ||
                                   (rad_sat == itoa_pkg::RADIX_BIN));
          p1_nxt    = !in_zero && ((rad_sat == itoa_pkg::RADIX_HEX) ||
                                   (rad_sat == itoa_pkg::RADIX_BIN));
          nd_nxt    = '0;
          state_nxt = S_START;
        end
      end
      S_START: begin
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (div_stat.done) begin
          push    = 1'b1;
          mag_nxt = div_quo;
          nd_nxt  = nd_r + itoa_pkg::ND_W'(1);
          state_nxt = (div_quo == '0) ? S_EMIT : S_START;
        end
      end
      S_EMIT: begin
        if (load_ok) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.last = 1'b0;
          priority if (neg_r) begin
            out_data_nxt.character = itoa_pkg::CHAR_MINUS;
            neg_nxt = 1'b0;
          end else if (p0_r) begin
            out_data_nxt.character = itoa_pkg::CHAR_ZERO;
            p0_nxt = 1'b0;
          end else if (p1_r) begin
            out_data_nxt.character = (rad_r == itoa_pkg::RADIX_HEX) ? itoa_pkg::CHAR_X
                                                                    : itoa_pkg::CHAR_B;
            p1_nxt = 1'b0;
          end else begin
            out_data_nxt.character = itoa_pkg::digit_char(stack_r[0]);
            out_data_nxt.last      = (nd_r == itoa_pkg::ND_W'(1));
            pop    = 1'b1;
            nd_nxt = nd_r - itoa_pkg::ND_W'(1);
            if (nd_r == itoa_pkg::ND_W'(1)) begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      neg_r       <= 1'b0;
      p0_r        <= 1'b0;
      p1_r        <= 1'b0;
      nd_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      neg_r       <= neg_nxt;
      p0_r        <= p0_nxt;
      p1_r        <= p1_nxt;
      nd_r        <= nd_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    rad_r      <= rad_nxt;
    out_data_r <= out_data_nxt;
  end

  // Digit stack: the newest digit (most significant so far) sits in entry 0.
  always_ff @(posedge clk) begin
    if (push) begin
      stack_r[0] <= div_rem;
      for (int i = 1; i < itoa_pkg::VALUE_BITS; i++) begin
        stack_r[i] <= stack_r[i-1];
      end
    end else if (pop) begin
      for (int i = 0; i < itoa_pkg::VALUE_BITS - 1; i++) begin
        stack_r[i] <= stack_r[i+1];
      end
    end
  end

  // A digit only arrives while the sequencer waits for it.
  `ASSERT_IMPL(a_done_in_wait, div_stat.done, state_r == S_WAIT, "divider done outside wait")
  // Sending text always has at least one digit left to send.
  `ASSERT_IMPL(a_emit_has_digit, state_r == S_EMIT, nd_r != '0, "emit with empty stack")
  // An accepted transaction starts a division in the next cycle.
  `ASSERT_NEXT(a_accept_starts, in_valid && !in_stall, state_r == S_START,
               "accepted transaction did not start a division")

endmodule
